>>> hw/rtl/spsa_pkg.sv
// ----------------------------------------------------------------------------
// Slot allocator package
// Shared widths, command and status codes, register map and the search
// token that travels along the row of slot cells.
// ----------------------------------------------------------------------------
package spsa_pkg;

   // Field widths of the request and response beats
   localparam int SIZE_W = 13;
   localparam int IDX_W  = 7;
   localparam int SLOT_W = 6;
   localparam int HDR_W  = 13;
   localparam int STAT_W = 2;

   // Offsets are kept wide enough for the largest supported page (64 KiB)
   localparam int OFF_W = 17;
   localparam int END_W = OFF_W + 1;
   localparam int SUM_W = END_W + 1;

   // Slot reset values
   localparam logic [SIZE_W-1:0] CAP_UNLIMITED = '1;
   localparam logic [OFF_W-1:0]  OFF_UNSET     = OFF_W'(13'h1FFF);

   // Command codes
   localparam logic CMD_ADD = 1'b0;
   localparam logic CMD_DEL = 1'b1;

   // Status codes
   localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
   localparam logic [STAT_W-1:0] ST_NO_FIT   = 2'd1;
   localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd2;
   localparam logic [STAT_W-1:0] ST_REFUSED  = 2'd3;

   // Register map
   localparam int                 CSR_ADDR_W      = 2;
   localparam logic [CSR_ADDR_W-1:0] CSR_HEADER_ADDR = 2'd0;
   localparam logic [HDR_W-1:0]   HEADER_RESET    = 13'd512;

   // Beat layout widths
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;
   localparam int RSP_PAY_W  = STAT_W + SLOT_W + SIZE_W;

   // Token handed from cell to cell
   typedef struct packed {
      logic              valid;
      logic              done;
      logic              cmd;
      logic [SIZE_W-1:0] size;
      logic [IDX_W-1:0]  idx;
      logic [END_W-1:0]  prev_end;
      logic [STAT_W-1:0] status;
      logic [SLOT_W-1:0] chosen;
      logic [SIZE_W-1:0] place;
   } token_type;

endpackage

>>> hw/rtl/spsa_cell.sv
// ----------------------------------------------------------------------------
// Slot cell
// Holds one slot (empty flag, capacity, offset), serves the token when it
// addresses or fits this slot, and hands the token to the next cell.
// ----------------------------------------------------------------------------
module spsa_cell
   import spsa_pkg::*;
#(
   parameter int CELL_ID    = 0,
   parameter int PAGE_BYTES = 4096
) (
   input  logic      clock,
   input  logic      reset,
   input  token_type tok_in,
   output token_type tok_out
);

   logic              empty_ff, empty_in;
   logic [SIZE_W-1:0] cap_ff, cap_in;
   logic [OFF_W-1:0]  off_ff, off_in;
   token_type         tok_ff, tok_in_nx;

   logic              hit_del;
   logic              fits;
   logic [SUM_W-1:0]  tuple_end;
   logic              in_page;

   assign hit_del   = ({25'd0, tok_in.idx} == 32'(CELL_ID));
   assign fits      = empty_ff && (cap_ff >= tok_in.size);
   assign tuple_end = SUM_W'(tok_in.prev_end) + SUM_W'(tok_in.size);
   assign in_page   = (tuple_end <= SUM_W'(PAGE_BYTES));

   // Serve the token or pass it on with this slot's end as the next start
   always_comb begin
      tok_in_nx = tok_in;
      empty_in  = empty_ff;
      cap_in    = cap_ff;
      off_in    = off_ff;
      if (tok_in.valid && !tok_in.done) begin
         if (tok_in.cmd == CMD_DEL) begin
            if (hit_del) begin
               tok_in_nx.done = 1'b1;
               if (empty_ff) begin
                  tok_in_nx.status = ST_REFUSED;
               end else begin
                  empty_in = 1'b1;
               end
            end
         end else if (fits) begin
            tok_in_nx.done = 1'b1;
            if (!in_page) begin
               tok_in_nx.status = ST_OVERFLOW;
            end else begin
               tok_in_nx.chosen = SLOT_W'(CELL_ID);
               tok_in_nx.place  = tok_in.prev_end[SIZE_W-1:0];
               off_in           = tok_in.prev_end[OFF_W-1:0];
               cap_in           = tok_in.size;
               empty_in         = 1'b0;
            end
         end
         if (!tok_in_nx.done) begin
            tok_in_nx.prev_end = END_W'(off_ff) + END_W'(cap_ff);
         end
      end
   end

   // Slot state and token stage
   always_ff @(posedge clock) begin
      if (reset) begin
         empty_ff     <= 1'b1;
         cap_ff       <= CAP_UNLIMITED;
         off_ff       <= OFF_UNSET;
         tok_ff.valid <= 1'b0;
      end else begin
         empty_ff     <= empty_in;
         cap_ff       <= cap_in;
         off_ff       <= off_in;
         tok_ff.valid <= tok_in_nx.valid;
      end
      // token payload needs no reset
      tok_ff.done     <= tok_in_nx.done;
      tok_ff.cmd      <= tok_in_nx.cmd;
      tok_ff.size     <= tok_in_nx.size;
      tok_ff.idx      <= tok_in_nx.idx;
      tok_ff.prev_end <= tok_in_nx.prev_end;
      tok_ff.status   <= tok_in_nx.status;
      tok_ff.chosen   <= tok_in_nx.chosen;
      tok_ff.place    <= tok_in_nx.place;
   end

   assign tok_out = tok_ff;

endmodule

>>> hw/rtl/slotted_page_slot_allocator_core.sv
// A request beat is registered in the entry stage and then its token walks
// the row of slot cells one cell per cycle, for adds and deletes alike; no
// new command is taken until the token has left the last cell.
// A finished response waits in an output register and a skid stage.
// Reset (synchronous, active high) empties all slots, sets capacity to all
// ones, offset to 0x1FFF and header_bytes to 512; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Slotted page slot allocator
// First-fit slot allocation and deletion for one page, built as a chain
// of slot cells with a stream request/response port and an APB register.
// ----------------------------------------------------------------------------
module slotted_page_slot_allocator_core
   import spsa_pkg::*;
#(
   parameter int SLOT_COUNT = 64,
   parameter int PAGE_BYTES = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   // req_tdata: command[0], tuple_size[13:1], slot_index[20:14], zero fill
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // rsp_tdata: status[1:0], chosen_slot[7:2], byte_offset[20:8], zero fill
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic [HDR_W-1:0] header_ff;
   logic             csr_wr;

   logic             busy_ff, busy_in;
   token_type        entry_ff, entry_in;
   token_type        chain [0:SLOT_COUNT];
   token_type        fin;
   logic [RSP_PAY_W-1:0] fin_data;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_PAY_W-1:0] rsp_data_ff, rsp_data_in;
   logic                 skid_valid_ff, skid_valid_in;
   logic [RSP_PAY_W-1:0] skid_data_ff, skid_data_in;
   logic                 rsp_free;
   logic                 req_beat;

   // Register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr == CSR_HEADER_ADDR);
   assign csr_prdata = (csr_paddr == CSR_HEADER_ADDR) ? {19'd0, header_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= HEADER_RESET;
      end else if (csr_wr) begin
         header_ff <= csr_pwdata[HDR_W-1:0];
      end
   end

   // Accept one beat at a time; hold off while the skid stage is occupied
   assign req_tready = !busy_ff && !skid_valid_ff;
   assign req_beat   = req_tvalid && req_tready;

   // Build the entry token
   always_comb begin
      entry_in          = entry_ff;
      entry_in.valid    = req_beat;
      entry_in.done     = 1'b0;
      entry_in.cmd      = req_tdata[0];
      entry_in.size     = req_tdata[SIZE_W:1];
      entry_in.idx      = req_tdata[SIZE_W+IDX_W:SIZE_W+1];
      entry_in.prev_end = END_W'(header_ff);
      entry_in.status   = ST_OK;
      entry_in.chosen   = '0;
      entry_in.place    = '0;
   end

   // Entry stage; the payload is captured only on a request beat
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
      if (req_beat) begin
         entry_ff.done     <= entry_in.done;
         entry_ff.cmd      <= entry_in.cmd;
         entry_ff.size     <= entry_in.size;
         entry_ff.idx      <= entry_in.idx;
         entry_ff.prev_end <= entry_in.prev_end;
         entry_ff.status   <= entry_in.status;
         entry_ff.chosen   <= entry_in.chosen;
         entry_ff.place    <= entry_in.place;
      end
   end

   // Row of slot cells
   assign chain[0] = entry_ff;

   for (genvar gi = 0; gi < SLOT_COUNT; gi++) begin : g_cell
      spsa_cell #(
         .CELL_ID    (gi),
         .PAGE_BYTES (PAGE_BYTES)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .tok_in  (chain[gi]),
         .tok_out (chain[gi+1])
      );
   end

   // Resolve a token that no cell served
   always_comb begin
      fin = chain[SLOT_COUNT];
      if (!fin.done) begin
         fin.status = (fin.cmd == CMD_DEL) ? ST_REFUSED : ST_NO_FIT;
      end
      fin_data = {fin.place, fin.chosen, fin.status};
   end

   // Output register with a skid stage behind it
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      busy_in       = busy_ff;
      if (rsp_free) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else if (fin.valid) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = fin_data;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
      if (fin.valid && !(rsp_free && !skid_valid_ff)) begin
         skid_valid_in = 1'b1;
         skid_data_in  = fin_data;
      end
      if (req_beat) begin
         busy_in = 1'b1;
      end else if (fin.valid) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
         busy_ff       <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
         busy_ff       <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - RSP_PAY_W)'(0), rsp_data_ff};

endmodule

>>> hw/rtl/spsa_checker.sv
// ----------------------------------------------------------------------------
// Slot allocator port checker
// Watches the top-level ports for response hold, zeroed fields on failure,
// single-command flow and register readback.
// ----------------------------------------------------------------------------
module spsa_checker
   import spsa_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  csr_psel,
   input logic                  csr_penable,
   input logic                  csr_pwrite,
   input logic [CSR_ADDR_W-1:0] csr_paddr,
   input logic [31:0]           csr_pwdata,
   input logic [31:0]           csr_prdata,
   input logic                  csr_pready
);

   // Hold a stalled response beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response beat changed while stalled");

   // Zero slot and offset unless the status is ok
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[1:0] != ST_OK) |-> (rsp_tdata[20:2] == 19'd0))
      else $error("failed command carries a slot or offset");

   // Take no second command right after one is accepted
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while a command is in flight");

   // Read back what was written to header_bytes
   a_csr_read: assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite && csr_pready &&
      (csr_paddr == CSR_HEADER_ADDR)
      |=> (csr_paddr != CSR_HEADER_ADDR) ||
          (csr_prdata == {19'd0, $past(csr_pwdata[HDR_W-1:0])}))
      else $error("header_bytes readback mismatch");

endmodule

bind slotted_page_slot_allocator_core spsa_checker u_spsa_checker (.*);
